FILE: hdl/ffra_pkg.sv
// Shared types and constants for the first-fit region allocator.
package ffra_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int ALIGN_BYTES   = 8;   // power of two
  localparam int ADDR_BITS     = 32;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int SIZE_W = ADDR_BITS + 1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic CFG_POOL_BASE   = 1'b0;
  localparam logic CFG_POOL_LENGTH = 1'b1;

  typedef struct packed {
    logic                 func;
    logic [ADDR_BITS-1:0] region_start;
    logic [ADDR_BITS-1:0] request_size;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] granted_addr;
    logic [1:0]           status;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] len;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } tbl_req_t;

endpackage

FILE: hdl/ffra_table.sv
// Free-region table memory: one write port, one registered read port.
module ffra_table
  import ffra_pkg::*;
(
  input  logic     clk,
  input  tbl_req_t req,
  output entry_t   rd_data
);

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/ffra_seq.sv
// Sequencer: table walk, merge, and shift steps around one shared datapath.
module ffra_seq
  import ffra_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_load,
  input  logic [ADDR_BITS-1:0] cfg_base,
  input  logic [ADDR_BITS-1:0] cfg_len,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  output tbl_req_t             tbl_req,
  input  entry_t               rd_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_WALK, S_ENDWALK, S_MERGE, S_INS, S_UP_RD, S_UP_WR,
    S_DN_RD, S_DN_WR, S_FIN
  } state_t;

  localparam logic [SIZE_W-1:0] ALIGN_M1 = SIZE_W'(ALIGN_BYTES - 1);

  state_t               state_r, state_nxt;
  logic                 func_r, func_nxt;
  logic [ADDR_BITS-1:0] start_r, start_nxt;
  logic [SIZE_W-1:0]    size_r, size_nxt;
  logic [ADDR_BITS-1:0] end_r, end_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     k_r, k_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [ADDR_BITS-1:0] cur_s_r, cur_s_nxt;
  logic [ADDR_BITS-1:0] cur_l_r, cur_l_nxt;
  logic [ADDR_BITS-1:0] res_addr_r, res_addr_nxt;
  logic [1:0]           res_status_r, res_status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_item_r, out_item_nxt;

  logic [SIZE_W-1:0]    rounded;
  logic [ADDR_BITS-1:0] size_w;
  logic [ADDR_BITS-1:0] rd_end;
  logic [CNT_W-1:0]     idx_inc;

  assign rounded = ({1'b0, in_item.request_size} + ALIGN_M1) & ~ALIGN_M1;
  assign size_w  = size_r[ADDR_BITS-1:0];
  assign rd_end  = rd_data.start + rd_data.len;
  assign idx_inc = idx_r + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    start_nxt      = start_r;
    size_nxt       = size_r;
    end_nxt        = end_r;
    idx_nxt        = idx_r;
    k_nxt          = k_r;
    count_nxt      = count_r;
    cur_s_nxt      = cur_s_r;
    cur_l_nxt      = cur_l_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_item_nxt   = out_item_r;
    tbl_req        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt       = in_item.func;
          start_nxt      = in_item.region_start;
          size_nxt       = rounded;
          end_nxt        = in_item.region_start + rounded[ADDR_BITS-1:0];
          idx_nxt        = '0;
          res_addr_nxt   = '0;
          res_status_nxt = ST_DONE;
          state_nxt      = (count_r == '0) ? S_ENDWALK : S_WALK;
        end
      end
      S_WALK: begin
        if (func_r == FUNC_ALLOC) begin
          if ({1'b0, rd_data.len} >= size_r) begin
            res_addr_nxt = rd_data.start;
            if ({1'b0, rd_data.len} == size_r) begin
              k_nxt     = idx_r;
              state_nxt = S_DN_RD;
            end else begin
              tbl_req.we          = 1'b1;
              tbl_req.waddr       = idx_r[IDX_W-1:0];
              tbl_req.wdata.start = rd_data.start + size_w;
              tbl_req.wdata.len   = rd_data.len - size_w;
              state_nxt           = S_FIN;
            end
          end else begin
            idx_nxt = idx_inc;
            if (idx_inc == count_r) state_nxt = S_ENDWALK;
            else tbl_req.raddr = idx_inc[IDX_W-1:0];
          end
        end else begin
          if (rd_data.start > end_r) begin
            state_nxt = S_INS;
          end else if (rd_end == start_r) begin
            cur_s_nxt           = rd_data.start;
            cur_l_nxt           = rd_data.len + size_w;
            tbl_req.we          = 1'b1;
            tbl_req.waddr       = idx_r[IDX_W-1:0];
            tbl_req.wdata.start = rd_data.start;
            tbl_req.wdata.len   = rd_data.len + size_w;
            if (idx_inc < count_r) begin
              tbl_req.raddr = idx_inc[IDX_W-1:0];
              state_nxt     = S_MERGE;
            end else begin
              state_nxt = S_FIN;
            end
          end else if (rd_data.start == end_r) begin
            tbl_req.we          = 1'b1;
            tbl_req.waddr       = idx_r[IDX_W-1:0];
            tbl_req.wdata.start = start_r;
            tbl_req.wdata.len   = rd_data.len + size_w;
            state_nxt           = S_FIN;
          end else begin
            idx_nxt = idx_inc;
            if (idx_inc == count_r) state_nxt = S_ENDWALK;
            else tbl_req.raddr = idx_inc[IDX_W-1:0];
          end
        end
      end
      S_ENDWALK: begin
        if (func_r == FUNC_ALLOC) begin
          res_status_nxt = ST_NOFIT;
          state_nxt      = S_FIN;
        end else begin
          state_nxt = S_INS;
        end
      end
      S_MERGE: begin
        if (cur_s_r + cur_l_r == rd_data.start) begin
          tbl_req.we          = 1'b1;
          tbl_req.waddr       = idx_r[IDX_W-1:0];
          tbl_req.wdata.start = cur_s_r;
          tbl_req.wdata.len   = cur_l_r + rd_data.len;
          k_nxt               = idx_inc;
          state_nxt           = S_DN_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_INS: begin
        if (count_r >= CNT_W'(TABLE_ENTRIES)) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_FIN;
        end else begin
          k_nxt     = count_r;
          state_nxt = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (k_r == idx_r) begin
          tbl_req.we          = 1'b1;
          tbl_req.waddr       = idx_r[IDX_W-1:0];
          tbl_req.wdata.start = start_r;
          tbl_req.wdata.len   = size_w;
          count_nxt           = count_r + 1'b1;
          state_nxt           = S_FIN;
        end else begin
          tbl_req.raddr = IDX_W'(k_r - 1'b1);
          state_nxt     = S_UP_WR;
        end
      end
      S_UP_WR: begin
        tbl_req.we    = 1'b1;
        tbl_req.waddr = k_r[IDX_W-1:0];
        tbl_req.wdata = rd_data;
        k_nxt         = k_r - 1'b1;
        state_nxt     = S_UP_RD;
      end
      S_DN_RD: begin
        if (k_r + 1'b1 >= count_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_FIN;
        end else begin
          tbl_req.raddr = IDX_W'(k_r + 1'b1);
          state_nxt     = S_DN_WR;
        end
      end
      S_DN_WR: begin
        tbl_req.we    = 1'b1;
        tbl_req.waddr = k_r[IDX_W-1:0];
        tbl_req.wdata = rd_data;
        k_nxt         = k_r + 1'b1;
        state_nxt     = S_DN_RD;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.granted_addr = res_addr_r;
          out_item_nxt.status       = res_status_r;
          state_nxt                 = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_load) begin
      tbl_req.we          = 1'b1;
      tbl_req.waddr       = '0;
      tbl_req.wdata.start = cfg_base;
      tbl_req.wdata.len   = cfg_len;
      count_nxt           = (cfg_len != '0) ? CNT_W'(1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r       <= func_nxt;
    start_r      <= start_nxt;
    size_r       <= size_nxt;
    end_r        <= end_nxt;
    idx_r        <= idx_nxt;
    k_r          <= k_nxt;
    cur_s_r      <= cur_s_nxt;
    cur_l_r      <= cur_l_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_item_r   <= out_item_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: hdl/first_fit_region_allocator.sv
// First-fit free-region allocator with coalescing: top level.
// Each item walks the table entries in order; an insert or removal then shifts entries one by one,
// each move a read followed by a write through the table's one read port and one write port,
// and the result is registered once out_stall allows it.
// Throughput: one item at a time; in_stall stays high until the result is registered.
// Reset: synchronous active-low; pool registers clear to zero, table starts empty.
module first_fit_region_allocator
  import ffra_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [ADDR_BITS-1:0] cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item
);

  logic [ADDR_BITS-1:0] pool_base_r, pool_base_nxt;
  logic [ADDR_BITS-1:0] pool_length_r, pool_length_nxt;
  tbl_req_t             tbl_req;
  entry_t               rd_data;

  always_comb begin
    pool_base_nxt   = pool_base_r;
    pool_length_nxt = pool_length_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_POOL_BASE:   pool_base_nxt   = cfg_wdata;
        CFG_POOL_LENGTH: pool_length_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r   <= '0;
      pool_length_r <= '0;
    end else begin
      pool_base_r   <= pool_base_nxt;
      pool_length_r <= pool_length_nxt;
    end
  end

  ffra_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_load  (cfg_we),
    .cfg_base  (pool_base_nxt),
    .cfg_len   (pool_length_nxt),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .tbl_req   (tbl_req),
    .rd_data   (rd_data)
  );

  ffra_table u_table (
    .clk     (clk),
    .req     (tbl_req),
    .rd_data (rd_data)
  );

endmodule
